FILE: rtl/srp_pkg.sv
// Shared types, constants and helpers of the sparse row pruner.
// Used by srp_cfg, srp_engine and the top level; depends on nothing.
package srp_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int AW          = $clog2(MAX_ENTRIES);
    localparam int CW          = $clog2(MAX_ENTRIES + 1);

    localparam int IDX_W      = 24;
    localparam int VAL_W      = 32;
    localparam int MAG_W      = 31;
    localparam int KEEP_W     = 7;
    localparam int ENT_W      = IDX_W + MAG_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(64);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG_ROW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd3;

    typedef enum logic [1:0] {
        MODE_ALL    = 2'd0,
        MODE_THRESH = 2'd1,
        MODE_FILL   = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode               mode;
        logic [IDX_W-1:0]    diag_row;
        logic [KEEP_W-1:0]   keep_count;
        logic [MAG_W-1:0]    threshold;
    } t_cfg;

    typedef struct packed {
        logic                we;
        logic [AW-1:0]       waddr;
        logic [ENT_W-1:0]    wdata;
        logic [AW-1:0]       raddr_a;
        logic [AW-1:0]       raddr_b;
    } t_ram_req;

    typedef struct packed {
        logic [IDX_W-1:0]    kept_index;
        logic                last_out;
        logic                empty_res;
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DRD,
        S_DCMP,
        S_DSW2,
        S_PSTART,
        S_KRD,
        S_KEY,
        S_RD,
        S_CMP,
        S_WR2,
        S_FRD,
        S_FIN,
        S_FIN2,
        S_CHK,
        S_ERD,
        S_EMIT,
        S_FLUSH
    } t_state;

    // Absolute value, the most negative code saturates to the largest positive one
    function automatic logic [MAG_W-1:0] f_magnitude(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] neg;
        neg = ~v + VAL_W'(1);
        if (!v[VAL_W-1]) begin
            return v[MAG_W-1:0];
        end else if (v == {1'b1, {(VAL_W-1){1'b0}}}) begin
            return {MAG_W{1'b1}};
        end else begin
            return neg[MAG_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/srp_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module srp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: rtl/srp_cfg.sv
// Configuration registers of the sparse row pruner.
// Depends on srp_pkg.
module srp_cfg
    import srp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Load the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= MODE_ALL;
            r_cfg.diag_row   <= '0;
            r_cfg.keep_count <= KEEP_RESET;
            r_cfg.threshold  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:      r_cfg.mode       <= t_mode'(i_cfg_data[1:0]);
                CFG_DIAG_ROW:  r_cfg.diag_row   <= i_cfg_data[IDX_W-1:0];
                CFG_KEEP:      r_cfg.keep_count <= i_cfg_data[KEEP_W-1:0];
                CFG_THRESHOLD: r_cfg.threshold  <= i_cfg_data[MAG_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/srp_engine.sv
// Row store control: loads entries, runs the diagonal search and the
// quick-split partition in the entry RAM, and selects the kept items.
// Depends on srp_pkg; drives the ports of one srp_ram.
module srp_engine
    import srp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [IDX_W-1:0]  i_col_index,
    input  logic [VAL_W-1:0]  i_value,
    input  logic              i_last_in,
    output t_ram_req          o_ram,
    input  logic [ENT_W-1:0]  i_rdata_a,
    input  logic [ENT_W-1:0]  i_rdata_b,
    input  logic              i_slot_free,
    output logic              o_push,
    output t_res              o_push_item
);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_n, n_n;
    logic [CW-1:0]     r_emit, n_emit;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [AW-1:0]     r_mid, n_mid;
    logic [AW-1:0]     r_first, n_first;
    logic [AW-1:0]     r_last, n_last;
    logic [AW-1:0]     r_target, n_target;
    logic              r_base, n_base;
    logic [MAG_W-1:0]  r_key, n_key;
    logic [ENT_W-1:0]  r_efirst, n_efirst;
    logic [ENT_W-1:0]  r_tmp, n_tmp;
    logic              r_pend_v, n_pend_v;
    logic [IDX_W-1:0]  r_pend_idx, n_pend_idx;

    logic [IDX_W-1:0]  a_idx;
    logic [MAG_W-1:0]  a_mag;
    logic              accept;
    logic              keep_hit;
    logic [CW-1:0]     n_row;
    logic [CW-1:0]     keep_cw;

    assign a_idx   = i_rdata_a[ENT_W-1 -: IDX_W];
    assign a_mag   = i_rdata_a[MAG_W-1:0];
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign keep_cw = CW'(i_cfg.keep_count);

    // Threshold mode drops small entries, the diagonal always stays
    assign keep_hit = (i_cfg.mode != MODE_THRESH) || (a_mag >= i_cfg.threshold) ||
                      (a_idx == i_cfg.diag_row);

    // Row length after this item, entries past the store are dropped
    assign n_row = (r_count < CW'(MAX_ENTRIES)) ? r_count + CW'(1) : r_count;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_emit     <= n_emit;
        r_ptr      <= n_ptr;
        r_mid      <= n_mid;
        r_first    <= n_first;
        r_last     <= n_last;
        r_target   <= n_target;
        r_base     <= n_base;
        r_key      <= n_key;
        r_efirst   <= n_efirst;
        r_tmp      <= n_tmp;
        r_pend_idx <= n_pend_idx;
    end

    // Next state, RAM accesses and output pushes
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_n         = r_n;
        n_emit      = r_emit;
        n_ptr       = r_ptr;
        n_mid       = r_mid;
        n_first     = r_first;
        n_last      = r_last;
        n_target    = r_target;
        n_base      = r_base;
        n_key       = r_key;
        n_efirst    = r_efirst;
        n_tmp       = r_tmp;
        n_pend_v    = r_pend_v;
        n_pend_idx  = r_pend_idx;
        o_ram.we      = 1'b0;
        o_ram.waddr   = r_ptr;
        o_ram.wdata   = i_rdata_a;
        o_ram.raddr_a = r_ptr;
        o_ram.raddr_b = r_mid + AW'(1);
        o_push        = 1'b0;
        o_push_item   = '{kept_index: r_pend_idx, last_out: 1'b0, empty_res: 1'b0};

        case (r_state)
            // Store entries, close the row on the last one
            S_IDLE: begin
                if (accept) begin
                    if (r_count < CW'(MAX_ENTRIES)) begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_count[AW-1:0];
                        o_ram.wdata = {i_col_index, f_magnitude(i_value)};
                    end
                    n_count = n_row;
                    if (i_last_in) begin
                        n_count  = '0;
                        n_n      = n_row;
                        n_ptr    = '0;
                        n_pend_v = 1'b0;
                        if (i_cfg.mode == MODE_FILL && n_row > keep_cw) begin
                            n_state = S_DRD;
                        end else begin
                            n_emit  = n_row;
                            n_state = S_ERD;
                        end
                    end
                end
            end
            // Find the first diagonal entry and swap it to the front
            S_DRD: begin
                o_ram.raddr_b = '0;
                n_state       = S_DCMP;
            end
            S_DCMP: begin
                if (a_idx == i_cfg.diag_row) begin
                    n_tmp       = i_rdata_b;
                    o_ram.we    = 1'b1;
                    o_ram.waddr = '0;
                    o_ram.wdata = i_rdata_a;
                    n_state     = S_DSW2;
                end else if (CW'(r_ptr) + CW'(1) == r_n) begin
                    n_base  = 1'b0;
                    n_state = S_PSTART;
                end else begin
                    n_ptr   = r_ptr + AW'(1);
                    n_state = S_DRD;
                end
            end
            S_DSW2: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_ptr;
                o_ram.wdata = r_tmp;
                n_base      = 1'b1;
                n_state     = S_PSTART;
            end
            // Set the partition window, or skip when the cut is already met
            S_PSTART: begin
                n_ptr    = '0;
                n_pend_v = 1'b0;
                n_emit   = keep_cw;
                if (i_cfg.keep_count == '0 ||
                    (r_base && i_cfg.keep_count == KEEP_W'(1))) begin
                    n_state = S_ERD;
                end else begin
                    n_first  = AW'(r_base);
                    n_last   = AW'(r_n - CW'(1));
                    n_target = AW'(i_cfg.keep_count - KEEP_W'(1));
                    n_state  = S_KRD;
                end
            end
            // Take the key from the window's first entry
            S_KRD: begin
                o_ram.raddr_a = r_first;
                n_state       = S_KEY;
            end
            S_KEY: begin
                n_key    = a_mag;
                n_efirst = i_rdata_a;
                n_mid    = r_first;
                n_ptr    = r_first + AW'(1);
                n_state  = (r_first == r_last) ? S_CHK : S_RD;
            end
            // Scan: move entries larger than the key behind the split point
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (a_mag > r_key) begin
                    n_tmp       = i_rdata_b;
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_mid + AW'(1);
                    o_ram.wdata = i_rdata_a;
                    n_state     = S_WR2;
                end else if (r_ptr == r_last) begin
                    n_state = S_FRD;
                end else begin
                    n_ptr   = r_ptr + AW'(1);
                    n_state = S_RD;
                end
            end
            S_WR2: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_ptr;
                o_ram.wdata = r_tmp;
                n_mid       = r_mid + AW'(1);
                if (r_ptr == r_last) begin
                    n_state = S_FRD;
                end else begin
                    n_ptr   = r_ptr + AW'(1);
                    n_state = S_RD;
                end
            end
            // Put the key entry at the split point
            S_FRD: begin
                o_ram.raddr_a = r_mid;
                n_state       = (r_mid == r_first) ? S_CHK : S_FIN;
            end
            S_FIN: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_first;
                o_ram.wdata = i_rdata_a;
                n_state     = S_FIN2;
            end
            S_FIN2: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_mid;
                o_ram.wdata = r_efirst;
                n_state     = S_CHK;
            end
            // Narrow the window toward the cut
            S_CHK: begin
                if (r_mid == r_target) begin
                    n_ptr    = '0;
                    n_pend_v = 1'b0;
                    n_emit   = keep_cw;
                    n_state  = S_ERD;
                end else if (r_mid > r_target) begin
                    n_last  = r_mid - AW'(1);
                    n_state = S_KRD;
                end else begin
                    n_first = r_mid + AW'(1);
                    n_state = S_KRD;
                end
            end
            // Walk the leading entries, hold one back to flag the last item
            S_ERD: begin
                n_state = (r_emit == '0) ? S_FLUSH : S_EMIT;
            end
            S_EMIT: begin
                if (!(keep_hit && r_pend_v && !i_slot_free)) begin
                    if (keep_hit) begin
                        o_push     = r_pend_v;
                        n_pend_v   = 1'b1;
                        n_pend_idx = a_idx;
                    end
                    if (CW'(r_ptr) + CW'(1) == r_emit) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_ptr   = r_ptr + AW'(1);
                        n_state = S_ERD;
                    end
                end
            end
            // Send the held item as the last one, or the empty marker
            S_FLUSH: begin
                if (i_slot_free) begin
                    o_push = 1'b1;
                    if (r_pend_v) begin
                        o_push_item = '{kept_index: r_pend_idx, last_out: 1'b1,
                                        empty_res: 1'b0};
                    end else begin
                        o_push_item = '{kept_index: '0, last_out: 1'b1, empty_res: 1'b1};
                    end
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Pushes only go into a free output slot
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_slot_free)
        else $error("item pushed into a full output slot");

    // The fill count never passes the store depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count beyond store depth");

    // The split point stays behind the scan pointer
    a_mid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_mid < r_ptr))
        else $error("split point caught up with scan");

    // The cut always lies inside the partition window
    a_target_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (r_target >= r_first && r_target <= r_last))
        else $error("cut outside partition window");

    // A closed row leaves the store empty for the next one
    a_row_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_in) |=> (r_count == '0 && r_state != S_IDLE))
        else $error("row not closed after last entry");

endmodule

FILE: rtl/sparse_row_pruner.sv
// Sparse row pruner top level: configuration, entry RAM, control and output register.
// Depends on srp_pkg, srp_cfg, srp_ram and srp_engine.
//
// Input channel (i_valid/o_ready) takes one row entry per item: column index,
// signed value and a last flag. Entries load one per cycle into the entry RAM.
// On the last entry the block stops taking items and selects the kept columns:
// keep all, keep by magnitude threshold (diagonal always kept), or keep keep_count entries:
// the diagonal if present plus the largest others, via an in-place quick-split partition.
// Output channel (o_valid/i_ready) gives one item per kept column with
// last_out on the final one, or a single empty_res item when nothing is kept.
// After the last entry, fill mode runs the diagonal search over the entries,
// swaps the first diagonal entry to the front and sets the partition window;
// each partition pass then takes the key, scans the window and places the key
// at the split point (passes shrink the window toward the cut). The selection
// walk reads each candidate entry and holds one back for the final item. All
// RAM writes go through the single write port of the entry RAM.
// A receiver stall holds the walk; the last item sits in the output register
// while the next row already loads. Reset clears control state and the
// configuration registers; the RAM needs no clearing pass.
module sparse_row_pruner
    import srp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IDX_W-1:0]      i_col_index,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                  i_last_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [IDX_W-1:0]      o_kept_index,
    output logic                  o_last_out,
    output logic                  o_empty_res
);

    t_cfg              cfg;
    t_ram_req          ram_req;
    logic [ENT_W-1:0]  rdata_a;
    logic [ENT_W-1:0]  rdata_b;
    logic              slot_free;
    logic              push;
    t_res              push_item;

    logic              r_ovalid;
    t_res              r_out;

    srp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    srp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_req.we),
        .i_waddr   (ram_req.waddr),
        .i_wdata   (ram_req.wdata),
        .i_raddr_a (ram_req.raddr_a),
        .i_raddr_b (ram_req.raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    srp_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_col_index (i_col_index),
        .i_value     (i_value),
        .i_last_in   (i_last_in),
        .o_ram       (ram_req),
        .i_rdata_a   (rdata_a),
        .i_rdata_b   (rdata_b),
        .i_slot_free (slot_free),
        .o_push      (push),
        .o_push_item (push_item)
    );

    assign slot_free = !r_ovalid || i_ready;

    // Output register: load on push, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (push) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= push_item;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_kept_index = r_out.kept_index;
    assign o_last_out   = r_out.last_out;
    assign o_empty_res  = r_out.empty_res;

endmodule
